FILE: design/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and constants for the encoder delta speed block.
// ----------------------------------------------------------------------------
package eds_pkg;

	localparam int CNT_W     = 16;
	localparam int TIME_W    = 32;
	localparam int SCALE_W   = 24;
	localparam int SPD_W     = 32;
	localparam int STAT_W    = 2;
	localparam int PROD_W    = CNT_W + SCALE_W;
	localparam int REM_W     = TIME_W + 1;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
	localparam logic [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

	// result status codes
	localparam logic [STAT_W-1:0] ST_BASELINE = 2'd0;
	localparam logic [STAT_W-1:0] ST_FRESH    = 2'd1;
	localparam logic [STAT_W-1:0] ST_CACHED   = 2'd2;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_SCALE = 1'b0,
		REG_FLIP  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_SAT,
		S_FLIP,
		S_DONE
	} state_t;

	// what the finished item does to state and output
	typedef enum logic [1:0] {
		K_NONE,
		K_BASE,
		K_CACHED,
		K_FRESH
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  prep;
		logic  mul;
		logic  div_step;
		logic  sat;
		logic  flip;
		logic  commit;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic baseline;
		logic same_ms;
		logic div_last;
	} stat_t;

endpackage

FILE: design/encoder_delta_speed.sv
// Path: a baseline, a same-millisecond repeat or an unknown wheel goes
//   from CHECK straight to DONE; a fresh speed also passes MUL, DIV, SAT, FLIP.
// Words are taken one at a time; the 40-step restoring divider makes
//   fresh words the slowest, and a stalled earlier result holds the
//   sequencer in DONE.
// Reset (arst_n low): control regs cleared, each wheel waits for a baseline.
// ----------------------------------------------------------------------------
// encoder_delta_speed
// Wheel speed from encoder count differences over millisecond timestamps.
// ----------------------------------------------------------------------------
module encoder_delta_speed #(
	parameter int NUM_WHEELS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             wheel,
	input  logic [eds_pkg::CNT_W-1:0]        count,
	input  logic [eds_pkg::TIME_W-1:0]       now_ms,
	input  logic                             restart,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [eds_pkg::SPD_W-1:0] speed,
	output logic [eds_pkg::STAT_W-1:0]       status,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [eds_pkg::ADDR_W-1:0]       paddr,
	input  logic [eds_pkg::DATA_W-1:0]       pwdata,
	output logic [eds_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);

	// Flow of one word:
	//   IDLE  take the word into the datapath
	//   CHECK look up the wheel: unknown wheel, baseline and same-millisecond
	//         words go straight to DONE; otherwise latch dt and |delta|
	//   MUL   |delta| * count_scale, 40 bits exact
	//   DIV   one quotient bit per cycle, 40 restoring steps
	//   SAT   clamp to signed 32 bits and apply the sign of delta
	//   FLIP  negate when direction_flip is set (most negative goes to max)
	//   DONE  wait for a free output register, write the result; baseline
	//         and fresh words also update the wheel's baseline and cached speed
	// The output register keeps a finished word while the next word is taken.

	logic [eds_pkg::SCALE_W-1:0] count_scale;
	logic                        direction_flip;
	eds_pkg::cmd_t               cmd;
	eds_pkg::stat_t              st;

	eds_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.count_scale    (count_scale),
		.direction_flip (direction_flip)
	);

	eds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	eds_dp #(
		.NUM_WHEELS (NUM_WHEELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.count_scale    (count_scale),
		.direction_flip (direction_flip),
		.wheel          (wheel),
		.count          (count),
		.now_ms         (now_ms),
		.restart        (restart),
		.speed          (speed),
		.status         (status)
	);

endmodule

FILE: design/eds_regs.sv
// ----------------------------------------------------------------------------
// eds_regs
// APB configuration registers: scale factor and direction flip.
// ----------------------------------------------------------------------------
module eds_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eds_pkg::ADDR_W-1:0]   paddr,
	input  logic [eds_pkg::DATA_W-1:0]   pwdata,
	output logic [eds_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [eds_pkg::SCALE_W-1:0]  count_scale,
	output logic                         direction_flip
);

	logic [eds_pkg::SCALE_W-1:0] count_scale_q;
	logic                        direction_flip_q;
	eds_pkg::reg_idx_t           idx;
	logic                        wr_en;

	assign idx   = eds_pkg::reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_scale_q    <= '0;
			direction_flip_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				eds_pkg::REG_SCALE: count_scale_q    <= pwdata[eds_pkg::SCALE_W-1:0];
				eds_pkg::REG_FLIP:  direction_flip_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			eds_pkg::REG_SCALE: prdata = eds_pkg::DATA_W'(count_scale_q);
			eds_pkg::REG_FLIP:  prdata = eds_pkg::DATA_W'(direction_flip_q);
			default:            prdata = '0;
		endcase
	end

	assign count_scale    = count_scale_q;
	assign direction_flip = direction_flip_q;

endmodule

FILE: design/eds_ctrl.sv
// ----------------------------------------------------------------------------
// eds_ctrl
// Sequencer: classify the word, run multiply and divide, hand off result.
// ----------------------------------------------------------------------------
module eds_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  eds_pkg::stat_t st,
	output eds_pkg::cmd_t  cmd
);

	eds_pkg::state_t state_q, state_d;
	eds_pkg::kind_t  kind_q, kind_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= eds_pkg::S_IDLE;
			kind_q      <= eds_pkg::K_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = kind_q;
		unique case (state_q)
			eds_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = eds_pkg::S_CHECK;
				end
			end
			eds_pkg::S_CHECK: begin
				if (!st.in_range) begin
					kind_d  = eds_pkg::K_NONE;
					state_d = eds_pkg::S_DONE;
				end else if (st.baseline) begin
					kind_d  = eds_pkg::K_BASE;
					state_d = eds_pkg::S_DONE;
				end else if (st.same_ms) begin
					kind_d  = eds_pkg::K_CACHED;
					state_d = eds_pkg::S_DONE;
				end else begin
					kind_d   = eds_pkg::K_FRESH;
					cmd.prep = 1'b1;
					state_d  = eds_pkg::S_MUL;
				end
			end
			eds_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = eds_pkg::S_DIV;
			end
			eds_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = eds_pkg::S_SAT;
				end
			end
			eds_pkg::S_SAT: begin
				cmd.sat = 1'b1;
				state_d = eds_pkg::S_FLIP;
			end
			eds_pkg::S_FLIP: begin
				cmd.flip = 1'b1;
				state_d  = eds_pkg::S_DONE;
			end
			eds_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = eds_pkg::S_IDLE;
				end
			end
			default: state_d = eds_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/eds_dp.sv
// ----------------------------------------------------------------------------
// eds_dp
// Datapath: per-wheel state, count/time differences, multiply, restoring
// divide, saturation and flip, output register.
// ----------------------------------------------------------------------------
module eds_dp #(
	parameter int NUM_WHEELS = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  eds_pkg::cmd_t                cmd,
	output eds_pkg::stat_t               st,
	input  logic [eds_pkg::SCALE_W-1:0]  count_scale,
	input  logic                         direction_flip,
	input  logic                         wheel,
	input  logic [eds_pkg::CNT_W-1:0]    count,
	input  logic [eds_pkg::TIME_W-1:0]   now_ms,
	input  logic                         restart,
	output logic signed [eds_pkg::SPD_W-1:0] speed,
	output logic [eds_pkg::STAT_W-1:0]   status
);

	localparam int WIDX = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

	// latched word
	logic                       wheel_q;
	logic [eds_pkg::CNT_W-1:0]  count_q;
	logic [eds_pkg::TIME_W-1:0] now_q;
	logic                       restart_q;

	// per-wheel state
	logic [eds_pkg::CNT_W-1:0]  base_count_q [NUM_WHEELS];
	logic [eds_pkg::TIME_W-1:0] base_time_q  [NUM_WHEELS];
	logic [eds_pkg::SPD_W-1:0]  cached_q     [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]      need_base_q;

	// arithmetic
	logic [eds_pkg::TIME_W-1:0]    dt_q;
	logic [eds_pkg::CNT_W-1:0]     mag_q;
	logic                          neg_q;
	logic [eds_pkg::REM_W-1:0]     rem_q;
	logic [eds_pkg::PROD_W-1:0]    quo_q;
	logic [eds_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [eds_pkg::SPD_W-1:0]     spd_q;
	logic [eds_pkg::SPD_W-1:0]     speed_q;
	logic [eds_pkg::STAT_W-1:0]    status_q;

	logic [WIDX-1:0]            widx;
	logic [eds_pkg::CNT_W-1:0]  diff;
	logic [eds_pkg::TIME_W-1:0] dt;
	logic [eds_pkg::REM_W-1:0]  rem_sh;
	logic [eds_pkg::REM_W-1:0]  dt_ext;
	logic                       ge;
	logic [eds_pkg::SPD_W-1:0]  sat_mag;
	logic                       fresh_wr;
	logic                       base_wr;

	assign widx   = WIDX'(wheel_q);
	assign diff   = count_q - base_count_q[widx];
	assign dt     = now_q - base_time_q[widx];

	assign st.in_range = (32'(wheel_q) < NUM_WHEELS);
	assign st.baseline = need_base_q[widx] || restart_q;
	assign st.same_ms  = (dt == '0);
	assign st.div_last = (div_cnt_q == eds_pkg::DIV_CNT_W'(eds_pkg::DIV_STEPS - 1));

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign dt_ext = {1'b0, dt_q};
	assign rem_sh = {rem_q[eds_pkg::REM_W-2:0], quo_q[eds_pkg::PROD_W-1]};
	assign ge     = (rem_sh >= dt_ext);

	// clamp the magnitude; a negative result may reach one further
	always_comb begin
		if (neg_q) begin
			sat_mag = (quo_q > eds_pkg::PROD_W'(eds_pkg::SPD_MIN)) ?
				eds_pkg::SPD_MIN : quo_q[eds_pkg::SPD_W-1:0];
		end else begin
			sat_mag = (quo_q > eds_pkg::PROD_W'(eds_pkg::SPD_MAX)) ?
				eds_pkg::SPD_MAX : quo_q[eds_pkg::SPD_W-1:0];
		end
	end

	assign base_wr  = cmd.commit && (cmd.kind == eds_pkg::K_BASE);
	assign fresh_wr = cmd.commit && (cmd.kind == eds_pkg::K_FRESH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_base_q <= '1;
		end else if (base_wr) begin
			need_base_q[widx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wheel_q   <= wheel;
			count_q   <= count;
			now_q     <= now_ms;
			restart_q <= restart;
		end
		if (cmd.prep) begin
			dt_q  <= dt;
			neg_q <= diff[eds_pkg::CNT_W-1];
			mag_q <= diff[eds_pkg::CNT_W-1] ? (eds_pkg::CNT_W'(0) - diff) : diff;
		end
		if (cmd.mul) begin
			quo_q     <= eds_pkg::PROD_W'(mag_q) * eds_pkg::PROD_W'(count_scale);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[eds_pkg::PROD_W-2:0], ge};
			rem_q     <= ge ? (rem_sh - dt_ext) : rem_sh;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.sat) begin
			spd_q <= neg_q ? (eds_pkg::SPD_W'(0) - sat_mag) : sat_mag;
		end else if (cmd.flip && direction_flip) begin
			spd_q <= (spd_q == eds_pkg::SPD_MIN) ? eds_pkg::SPD_MAX :
				(eds_pkg::SPD_W'(0) - spd_q);
		end
		if (base_wr || fresh_wr) begin
			base_count_q[widx] <= count_q;
			base_time_q[widx]  <= now_q;
			cached_q[widx]     <= base_wr ? '0 : spd_q;
		end
		if (cmd.commit) begin
			case (cmd.kind)
				eds_pkg::K_FRESH: begin
					speed_q  <= spd_q;
					status_q <= eds_pkg::ST_FRESH;
				end
				eds_pkg::K_CACHED: begin
					speed_q  <= cached_q[widx];
					status_q <= eds_pkg::ST_CACHED;
				end
				default: begin
					speed_q  <= '0;
					status_q <= eds_pkg::ST_BASELINE;
				end
			endcase
		end
	end

	assign speed  = signed'(speed_q);
	assign status = status_q;

endmodule

FILE: design/eds_checker.sv
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks for encoder_delta_speed, bound to the top level.
// ----------------------------------------------------------------------------
module eds_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [eds_pkg::SPD_W-1:0] speed,
	input logic [eds_pkg::STAT_W-1:0]       status
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed) && $stable(status))
		else $error("result word changed while stalled");

	// one word in flight: no second word right behind an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == eds_pkg::ST_BASELINE) || (status == eds_pkg::ST_FRESH) ||
			(status == eds_pkg::ST_CACHED))
		else $error("unused status code");

	a_baseline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == eds_pkg::ST_BASELINE) |-> speed == '0)
		else $error("baseline word with nonzero speed");

endmodule

bind encoder_delta_speed eds_checker u_eds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.speed     (speed),
	.status    (status)
);
